@@ design/fctt_pkg.sv @@
// shared types and constants of the foot contact timing tracker
package fctt_pkg;
  localparam int ENVS_DEF = 16;
  localparam int FEET_DEF = 4;

  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_STEP      = 3'd1;
  localparam logic [2:0] KIND_FORCE     = 3'd2;
  localparam logic [2:0] KIND_CONTACT   = 3'd3;
  localparam logic [2:0] KIND_CLR_STEP  = 3'd4;
  localparam logic [2:0] KIND_CLR_RESET = 3'd5;

  localparam logic CFG_SIM_DT  = 1'b0;
  localparam logic CFG_CTRL_DT = 1'b1;

  localparam logic [19:0] SIM_DT_RST  = 20'd1000;
  localparam logic [19:0] CTRL_DT_RST = 20'd20000;

  typedef struct packed {
    logic               flag;
    logic        [31:0] ct;
    logic        [31:0] at;
    logic signed [31:0] peak;
    logic               td;
    logic        [31:0] tdf;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } fctt_ent_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } fctt_mag_rsp_t;
endpackage

@@ design/fctt_mag.sv @@
// force magnitude unit: shared squarer then bit-pair square root
module fctt_mag import fctt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  fx,
  input  logic signed [31:0]  fy,
  input  logic signed [31:0]  fz,
  output fctt_mag_rsp_t       rsp
);
  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SQ   = 2'd1;
  localparam logic [1:0] M_ACC  = 2'd2;
  localparam logic [1:0] M_RT   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        done_r, done_nxt;
  logic signed [31:0] opnd;
  logic [31:0] mag;
  logic [63:0] trial;

  always_comb begin
    unique case (cnt_r)
      2'd0:    opnd = fx;
      2'd1:    opnd = fy;
      default: opnd = fz;
    endcase
    mag = opnd[31] ? 32'(-opnd) : 32'(opnd);
    trial = res_r + bit_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          state_nxt = M_SQ;
          cnt_nxt   = 2'd0;
          acc_nxt   = '0;
          prod_nxt  = '0;
        end
      end
      M_SQ: begin
        prod_nxt = {32'd0, mag} * {32'd0, mag};
        acc_nxt  = acc_r + prod_r;
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd2) state_nxt = M_ACC;
      end
      M_ACC: begin
        acc_nxt   = acc_r + prod_r;
        res_nxt   = '0;
        bit_nxt   = 64'd1 << 62;
        state_nxt = M_RT;
      end
      default: begin
        if (acc_r >= trial) begin
          acc_nxt = acc_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 64'd1) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];
endmodule

@@ design/foot_contact_timing_tracker_core.sv @@
// foot contact timing tracker: slot memory, sequencer and result register
// tick/force/contact read the slot and write it back; a step also runs the magnitude unit on
// first contact and waits for a free output before it writes back; clear kinds read and write
// each foot of the env in turn; one item in work at a time, the input stalling unless idle
// after reset a clearing pass writes every slot, with no item taken
module foot_contact_timing_tracker_core import fctt_pkg::*; #(
  parameter int ENVS = ENVS_DEF,
  parameter int FEET = FEET_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [3:0]         in_env_index,
  input  logic [1:0]         in_foot_index,
  input  logic               in_contact_bit,
  input  logic               in_history_given,
  input  logic signed [31:0] in_foot_height,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_force_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_env,
  output logic [1:0]         out_foot,
  output logic               out_in_contact,
  output logic               out_first_contact,
  output logic [31:0]        out_contact_time_us,
  output logic [31:0]        out_air_time_us,
  output logic [31:0]        out_landing_force,
  output logic signed [31:0] out_peak_height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [19:0]        cfg_data
);
  localparam int SLOTS  = ENVS * FEET;
  localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int FC_W   = $clog2(FEET + 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MAG  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  fctt_ent_t mem [SLOTS];
  fctt_ent_t rdata_r, wk_r, wk_nxt, wdata;
  logic      we;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  init_r, init_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [SLOT_W-1:0] addr_r, addr_nxt, waddr;
  logic [19:0]       sim_dt_r, ctrl_dt_r;
  logic [2:0]        kind_r;
  logic [3:0]        env_r;
  logic [1:0]        foot_r;
  logic              cbit_r, hist_r, first_r, first_nxt;
  logic signed [31:0] h_r, fx_r, fy_r, fz_r;
  logic              out_valid_r, out_valid_nxt;
  logic              mag_start;
  fctt_mag_rsp_t     mag_rsp;
  logic              acc_in, item_ok, out_free;
  logic [31:0]       sdt, cdt, dt, ct_a, at_a;
  logic [32:0]       ct_s, at_s;
  logic              touch;

  fctt_mag u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mag_start),
    .fx    (rdata_r.fx),
    .fy    (rdata_r.fy),
    .fz    (rdata_r.fz),
    .rsp   (mag_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign acc_in    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    item_ok = 1'b0;
    if (32'(in_env_index) < ENVS) begin
      if (in_kind == KIND_CLR_STEP || in_kind == KIND_CLR_RESET) item_ok = 1'b1;
      else if (in_kind <= KIND_CONTACT && 32'(in_foot_index) < FEET) item_ok = 1'b1;
    end
  end

  always_comb begin
    sdt   = (sim_dt_r == '0) ? 32'd1 : {12'd0, sim_dt_r};
    cdt   = (ctrl_dt_r == '0) ? 32'd1 : {12'd0, ctrl_dt_r};
    touch = (kind_r == KIND_TICK) ? cbit_r : rdata_r.flag;
    dt    = (kind_r == KIND_TICK) ? sdt : cdt;
    ct_s  = {1'b0, rdata_r.ct} + {1'b0, dt};
    at_s  = {1'b0, rdata_r.at} + {1'b0, dt};
    ct_a  = touch ? (ct_s[32] ? '1 : ct_s[31:0]) : '0;
    at_a  = touch ? '0 : (at_s[32] ? '1 : at_s[31:0]);
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    fc_nxt        = fc_r;
    addr_nxt      = addr_r;
    wk_nxt        = wk_r;
    first_nxt     = first_r;
    we            = 1'b0;
    waddr         = addr_r;
    wdata         = rdata_r;
    mag_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_r[SLOT_W-1:0];
        wdata = '0;
        init_nxt = init_r + CNT_W'(1);
        if (init_r == CNT_W'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc_in && item_ok) begin
          fc_nxt = '0;
          if (in_kind == KIND_CLR_STEP || in_kind == KIND_CLR_RESET)
            addr_nxt = SLOT_W'(32'(in_env_index) * FEET);
          else
            addr_nxt = SLOT_W'(32'(in_env_index) * FEET + 32'(in_foot_index));
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (kind_r)
          KIND_TICK: begin
            we = 1'b1;
            wdata.ct = ct_a;
            wdata.at = at_a;
            wdata.flag = cbit_r;
            state_nxt = S_IDLE;
          end
          KIND_FORCE: begin
            we = 1'b1;
            wdata.fx = fx_r;
            wdata.fy = fy_r;
            wdata.fz = fz_r;
            state_nxt = S_IDLE;
          end
          KIND_CONTACT: begin
            we = 1'b1;
            wdata.flag = cbit_r;
            state_nxt = S_IDLE;
          end
          KIND_STEP: begin
            wk_nxt = rdata_r;
            if (!hist_r) begin
              wk_nxt.ct = ct_a;
              wk_nxt.at = at_a;
            end
            first_nxt = touch && (wk_nxt.ct != '0) && (wk_nxt.ct <= cdt);
            wk_nxt.td = first_nxt;
            wk_nxt.tdf = '0;
            if (!touch && h_r > rdata_r.peak) wk_nxt.peak = h_r;
            if (first_nxt) begin
              mag_start = 1'b1;
              state_nxt = S_MAG;
            end else begin
              state_nxt = S_FIN;
            end
          end
          default: begin
            we = 1'b1;
            wdata.flag = 1'b0;
            if (rdata_r.td) wdata.peak = '0;
            wdata.td  = 1'b0;
            wdata.tdf = '0;
            wdata.fx  = '0;
            wdata.fy  = '0;
            wdata.fz  = '0;
            if (kind_r == KIND_CLR_RESET) begin
              wdata.ct   = '0;
              wdata.at   = '0;
              wdata.peak = '0;
            end
            if (fc_r == FC_W'(FEET - 1)) begin
              state_nxt = S_IDLE;
            end else begin
              fc_nxt    = fc_r + FC_W'(1);
              addr_nxt  = addr_r + SLOT_W'(1);
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_MAG: begin
        if (mag_rsp.done) begin
          wk_nxt.tdf = mag_rsp.root;
          state_nxt  = S_FIN;
        end
      end
      default: begin
        if (out_free) begin
          we = 1'b1;
          wdata = wk_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      sim_dt_r    <= SIM_DT_RST;
      ctrl_dt_r   <= CTRL_DT_RST;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SIM_DT) sim_dt_r <= cfg_data;
        else ctrl_dt_r <= cfg_data;
      end
    end
    fc_r    <= fc_nxt;
    addr_r  <= addr_nxt;
    wk_r    <= wk_nxt;
    first_r <= first_nxt;
    if (acc_in) begin
      kind_r <= in_kind;
      env_r  <= in_env_index;
      foot_r <= in_foot_index;
      cbit_r <= in_contact_bit;
      hist_r <= in_history_given;
      h_r    <= in_foot_height;
      fx_r   <= in_force_x;
      fy_r   <= in_force_y;
      fz_r   <= in_force_z;
    end
    if (state_r == S_FIN && out_free) begin
      out_env             <= env_r;
      out_foot            <= foot_r;
      out_in_contact      <= wk_r.flag;
      out_first_contact   <= first_r;
      out_contact_time_us <= wk_r.ct;
      out_air_time_us     <= wk_r.at;
      out_landing_force   <= wk_r.tdf;
      out_peak_height     <= wk_r.peak;
    end
  end

  assign out_valid = out_valid_r;
endmodule
